/* sv/rpf_pkg.sv */
package rpf_pkg;

  // field widths
  localparam int unsigned CLIENT_W = 64;
  localparam int unsigned TICK_W   = 64;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned BUDGET_W = 21;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned SHIFT_W  = 208;
  localparam int unsigned BCNT_W   = 5;

  // fnv-1a-32
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  // framing
  localparam logic [BUDGET_W-1:0] FRAME_BYTES  = 21'd25;
  localparam logic [BCNT_W-1:0]   HDR_BYTES    = 5'd21;
  localparam logic [BCNT_W-1:0]   RECORD_BYTES = 5'd26;
  localparam logic [BCNT_W-1:0]   CSUM_BYTES   = 5'd4;
  // ceil(2^24 / 13): halve, multiply, keep bits 24 and up gives x / 26
  localparam logic [20:0]         DIV_RECIP    = 21'd1290556;

  // item kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MAX_RECORDS = 2'd0;
  localparam logic [1:0] REG_BYTE_BUDGET = 2'd1;
  localparam logic [1:0] REG_MESSAGE_ID  = 2'd2;

endpackage

/* sv/rpf_if.sv */
interface rpf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] client_id;
  logic [63:0] snapshot_tick;
  logic [7:0]  reliability;
  logic [15:0] records_available;
  logic [7:0]  record_kind;
  logic [31:0] entity_id;
  logic [63:0] version_and_flags;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [7:0]  priority_req;

  modport source (
    output valid, kind, client_id, snapshot_tick, reliability, records_available,
           record_kind, entity_id, version_and_flags, pos_x, pos_y, pos_z, priority_req,
    input  ready
  );
  modport sink (
    input  valid, kind, client_id, snapshot_tick, reliability, records_available,
           record_kind, entity_id, version_and_flags, pos_x, pos_y, pos_z, priority_req,
    output ready
  );
endinterface

interface rpf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        packet_end;
  logic        budget_error;
  logic [15:0] record_count;

  modport source (
    output valid, out_byte, last_of_run, packet_end, budget_error, record_count,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_run, packet_end, budget_error, record_count,
    output ready
  );
endinterface

/* sv/record_packet_framer_fnv.sv */
// channel  | dir | handshake       | carries
// items    | in  | valid / ready   | start item (header fields) or one record
// stream   | out | valid / ready   | one wire byte with run, end and error flags
// apb      | in  | psel / penable  | max_records, byte_budget, message_id
//
// one byte leaves per cycle through the output register while the stream is
// ready; the fnv hash register steps with each byte. a record item sends 26
// bytes, 30 when it closes the packet. a start item passes the division state
// when a budget is set, then the header state, and sends 21 bytes, 25 for an
// empty packet. an error start sends one byte, an ignored record none.
// rst is synchronous and active high; no clearing pass is needed.
// items.ready is high only while the sequencer is idle; a stalled stream simply
// holds the sequencer where it is.
module record_packet_framer_fnv (
  input  logic             clk,
  input  logic             rst,
  rpf_in_if.sink           items,
  rpf_out_if.source        stream,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_HDR  = 5'b00100,
    S_SEND = 5'b01000,
    S_ERR  = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [rpf_pkg::COUNT_W-1:0]  max_records;
  logic [rpf_pkg::BUDGET_W-1:0] byte_budget;
  logic [rpf_pkg::COUNT_W-1:0]  message_id;

  // packet state
  logic [rpf_pkg::HASH_W-1:0]   running_hash;
  logic [rpf_pkg::COUNT_W-1:0]  records_left;
  logic [rpf_pkg::COUNT_W-1:0]  packet_count;
  logic                         packet_open;

  // byte sequencer
  logic [rpf_pkg::SHIFT_W-1:0]  sreg;
  logic [rpf_pkg::BCNT_W-1:0]   bcnt;
  logic                         csum;
  logic                         close;

  // divider and header scratch
  logic [rpf_pkg::BUDGET_W-1:0] dq;
  logic                         has_budget;
  logic [rpf_pkg::COUNT_W-1:0]  avail;

  // output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_end;
  logic        out_err;
  logic [15:0] out_count;

  logic                         accept;
  logic                         slot_free;
  logic                         emit;
  logic                         budget_small;
  logic                         last_byte;
  logic                         go_csum;
  logic [rpf_pkg::HASH_W-1:0]   hash_next;
  logic [40:0]                  div_prod;
  logic [rpf_pkg::COUNT_W-1:0]  fit;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid & items.ready;
  assign slot_free   = ~out_valid | stream.ready;
  assign emit        = slot_free & ((state == S_SEND) | (state == S_ERR));

  assign budget_small = (byte_budget != '0) && (byte_budget < rpf_pkg::FRAME_BYTES);
  assign last_byte    = (bcnt == 5'd1);
  assign go_csum      = last_byte & ~csum & close;

  // the shared fnv step: xor in the byte, multiply by the prime
  assign hash_next = 32'((running_hash ^ {24'b0, sreg[7:0]}) * rpf_pkg::FNV_PRIME);

  // division by 26: halve, then reciprocal multiply for 13
  assign div_prod = {21'b0, dq[rpf_pkg::BUDGET_W-1:1]} * {20'b0, rpf_pkg::DIV_RECIP};

  // record count from the queued records, the budget limit and max_records
  always_comb begin
    fit = avail;
    if (has_budget && (dq < {5'b0, fit})) begin
      fit = dq[rpf_pkg::COUNT_W-1:0];
    end
    if (fit > max_records) begin
      fit = max_records;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      max_records <= 16'hFFFF;
      byte_budget <= '0;
      message_id  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rpf_pkg::REG_MAX_RECORDS: max_records <= pwdata[15:0];
        rpf_pkg::REG_BYTE_BUDGET: byte_budget <= pwdata[rpf_pkg::BUDGET_W-1:0];
        rpf_pkg::REG_MESSAGE_ID:  message_id  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rpf_pkg::REG_MAX_RECORDS: prdata = {16'b0, max_records};
      rpf_pkg::REG_BYTE_BUDGET: prdata = {11'b0, byte_budget};
      rpf_pkg::REG_MESSAGE_ID:  prdata = {16'b0, message_id};
      default:                  prdata = '0;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= rpf_pkg::FNV_BASIS;
      records_left <= '0;
      packet_count <= '0;
      packet_open  <= 1'b0;
      out_valid    <= 1'b0;
      bcnt         <= '0;
      csum         <= 1'b0;
      close        <= 1'b0;
      has_budget   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (items.kind == rpf_pkg::KIND_START) begin
              if (budget_small) begin
                packet_open  <= 1'b0;
                records_left <= '0;
                packet_count <= '0;
                state        <= S_ERR;
              end else begin
                has_budget <= (byte_budget != '0);
                state      <= (byte_budget != '0) ? S_DIV : S_HDR;
              end
            end else if (packet_open && (records_left != '0)) begin
              records_left <= records_left - 16'd1;
              close        <= (records_left == 16'd1);
              csum         <= 1'b0;
              bcnt         <= rpf_pkg::RECORD_BYTES;
              state        <= S_SEND;
            end
          end
        end
        S_DIV: begin
          state <= S_HDR;
        end
        S_HDR: begin
          packet_count <= fit;
          records_left <= fit;
          packet_open  <= 1'b1;
          running_hash <= rpf_pkg::FNV_BASIS;
          close        <= (fit == '0);
          csum         <= 1'b0;
          bcnt         <= rpf_pkg::HDR_BYTES;
          state        <= S_SEND;
        end
        S_SEND: begin
          if (slot_free) begin
            running_hash <= hash_next;
            if (go_csum) begin
              // data done, the checksum bytes follow in the same run
              bcnt         <= rpf_pkg::CSUM_BYTES;
              csum         <= 1'b1;
              packet_open  <= 1'b0;
              records_left <= '0;
            end else begin
              bcnt <= bcnt - 5'd1;
              if (last_byte) begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: shift register, divider datapath and output register
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          avail <= items.records_available;
          dq    <= 21'(byte_budget - rpf_pkg::FRAME_BYTES);
          if (items.kind == rpf_pkg::KIND_START) begin
            // header little-endian, record count patched in later
            sreg <= {40'b0, 16'b0, items.reliability, items.snapshot_tick,
                     items.client_id, message_id};
          end else begin
            sreg <= {items.priority_req, items.pos_z, items.pos_y, items.pos_x,
                     items.version_and_flags, items.entity_id, items.record_kind};
          end
        end
      end
      S_DIV: begin
        dq <= {4'b0, div_prod[40:24]};
      end
      S_HDR: begin
        sreg[167:152] <= fit;
      end
      S_SEND: begin
        if (slot_free) begin
          out_byte  <= sreg[7:0];
          out_last  <= last_byte & ~go_csum;
          out_end   <= last_byte & csum;
          out_err   <= 1'b0;
          out_count <= packet_count;
          if (go_csum) begin
            sreg <= {176'b0, hash_next};
          end else begin
            sreg <= {8'b0, sreg[rpf_pkg::SHIFT_W-1:8]};
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_byte  <= '0;
          out_last  <= 1'b1;
          out_end   <= 1'b0;
          out_err   <= 1'b1;
          out_count <= '0;
        end
      end
      default: ;
    endcase
  end

  assign stream.valid        = out_valid;
  assign stream.out_byte     = out_byte;
  assign stream.last_of_run  = out_last;
  assign stream.packet_end   = out_end;
  assign stream.budget_error = out_err;
  assign stream.record_count = out_count;

  // checks
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.packet_end |-> stream.last_of_run)
    else $error("packet end without end of run");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.budget_error |-> stream.last_of_run && stream.record_count == 16'd0)
    else $error("error result malformed");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    records_left <= packet_count)
    else $error("records left above packet count");

  a_send_count: assert property (@(posedge clk) disable iff (rst)
    state == S_SEND |-> bcnt != '0)
    else $error("byte counter empty while sending");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_HDR)
    else $error("division did not hand over to header");

endmodule
